>>> hw/rtl/wadx_pkg.sv
package wadx_pkg;

    localparam int PRICE_BITS   = 32;
    localparam int PERIOD_MAX   = 64;
    localparam int PERIOD_BITS  = 7;
    localparam int COUNT_BITS   = 8;
    localparam int FRAC_BITS    = 16;
    localparam int SUM_BITS     = 54;
    localparam int PCT_BITS     = 23;
    localparam int SEED_BITS    = 30;
    localparam int MUL_BITS     = 31;
    localparam int STEP_BITS    = 5;
    localparam int DIV_CNT_BITS = 6;

    localparam logic [PCT_BITS-1:0] PCT_SCALE = 23'd6553600;

    typedef logic [SUM_BITS-1:0]    sum_t;
    typedef logic [PCT_BITS-1:0]    pct_t;
    typedef logic [PERIOD_BITS-1:0] period_t;
    typedef logic [PRICE_BITS-1:0]  price_t;

endpackage

>>> hw/rtl/wadx_div.sv
module wadx_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  wadx_pkg::sum_t   dividend,
    input  wadx_pkg::period_t divisor,
    output logic             done,
    output wadx_pkg::sum_t   quotient
);
    import wadx_pkg::*;

    localparam logic [DIV_CNT_BITS-1:0] CNT_LAST = DIV_CNT_BITS'(SUM_BITS - 1);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    sum_t                    quo_reg, quo_next;
    period_t                 rem_reg, rem_next;
    logic [PERIOD_BITS:0]    trial;
    logic                    ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[SUM_BITS-1]};
        ge        = trial >= {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? PERIOD_BITS'(trial - {1'b0, divisor}) : PERIOD_BITS'(trial);
            quo_next = {quo_reg[SUM_BITS-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hw/rtl/wadx_ratio.sv
module wadx_ratio (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  wadx_pkg::sum_t num,
    input  wadx_pkg::sum_t den,
    output logic           done,
    output wadx_pkg::pct_t ratio
);
    import wadx_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    sum_t                 num_reg, num_next;
    sum_t                 den_reg, den_next;
    sum_t                 r_reg, r_next;
    pct_t                 q_reg, q_next;
    logic [SUM_BITS+1:0]  r2;
    logic [SUM_BITS+1:0]  den1;
    logic [SUM_BITS+1:0]  den2;

    always_comb
    begin
        r2   = {1'b0, r_reg, 1'b0} + (PCT_SCALE[step_reg] ? {2'b00, num_reg} : '0);
        den1 = {2'b00, den_reg};
        den2 = {1'b0, den_reg, 1'b0};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        if (start)
        begin
            num_next = num;
            den_next = den;
            r_next   = '0;
            if (num >= den)
            begin
                q_next    = PCT_SCALE;
                done_next = 1'b1;
            end
            else
            begin
                q_next    = '0;
                busy_next = 1'b1;
                step_next = STEP_BITS'(PCT_BITS - 1);
            end
        end
        else if (busy_reg)
        begin
            if (r2 >= den2)
            begin
                r_next = SUM_BITS'(r2 - den2);
                q_next = PCT_BITS'({q_reg, 1'b0} + 2'd2);
            end
            else if (r2 >= den1)
            begin
                r_next = SUM_BITS'(r2 - den1);
                q_next = PCT_BITS'({q_reg, 1'b0} + 2'd1);
            end
            else
            begin
                r_next = SUM_BITS'(r2);
                q_next = PCT_BITS'({q_reg, 1'b0});
            end
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
    end

    assign done  = done_reg;
    assign ratio = q_reg;

endmodule

>>> hw/rtl/wilder_adx_indicator.sv
// The first bar goes straight to the output, and a bar before the DI values start only adds to
// the Wilder sums. A bar in the steady phase takes three passes of the shared bit-serial divider
// for the Wilder sums, two ratio passes for the DI values, one for DX and an ADX update.
// The block takes one item at a time; a held result stalls the input.
// Reset clears the control state, the sums and the ADX and sets the period to 14; there is no clearing pass.
module wilder_adx_indicator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [6:0]                 cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [31:0]                bar_high,
    input  logic [31:0]                bar_low,
    input  logic [31:0]                bar_close,
    output logic                       out_valid,
    input  logic                       out_ready,
    output wadx_pkg::pct_t             plus_di,
    output wadx_pkg::pct_t             down_di,
    output wadx_pkg::pct_t             adx_value,
    output logic                       di_valid,
    output logic                       adx_valid
);
    import wadx_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SUM    = 4'd1;
    localparam logic [3:0] ST_DIVW   = 4'd2;
    localparam logic [3:0] ST_PHASE  = 4'd3;
    localparam logic [3:0] ST_RSTART = 4'd4;
    localparam logic [3:0] ST_RWAIT  = 4'd5;
    localparam logic [3:0] ST_DX     = 4'd6;
    localparam logic [3:0] ST_ADX    = 4'd7;
    localparam logic [3:0] ST_AMUL   = 4'd8;
    localparam logic [3:0] ST_AWAIT  = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    localparam period_t PERIOD_RESET = 7'd14;
    localparam period_t PERIOD_TOP   = PERIOD_BITS'(PERIOD_MAX);
    localparam int      PAD_BITS     = SUM_BITS - PRICE_BITS - FRAC_BITS;

    logic [3:0]            state_reg, state_next;
    period_t               period_reg, period_next;
    price_t                prior_high_reg, prior_high_next;
    price_t                prior_low_reg, prior_low_next;
    price_t                prior_close_reg, prior_close_next;
    logic [COUNT_BITS-1:0] bars_reg, bars_next;
    sum_t                  range_reg, range_next;
    sum_t                  up_reg, up_next;
    sum_t                  down_reg, down_next;
    logic [SEED_BITS-1:0]  seed_reg, seed_next;
    pct_t                  adx_reg, adx_next;
    logic                  undef_reg, undef_next;

    price_t                tr_reg, tr_next;
    price_t                pdm_reg, pdm_next;
    price_t                mdm_reg, mdm_next;
    period_t               p_reg, p_next;
    logic [COUNT_BITS-1:0] i_reg, i_next;
    logic [1:0]            k_reg, k_next;
    pct_t                  pdi_reg, pdi_next;
    pct_t                  mdi_reg, mdi_next;
    pct_t                  dx_reg, dx_next;
    logic [MUL_BITS-1:0]   mul_reg, mul_next;
    logic                  di_ok_reg, di_ok_next;
    logic                  adx_ok_reg, adx_ok_next;

    logic                  out_valid_reg, out_valid_next;
    pct_t                  plus_reg, plus_next;
    pct_t                  minus_reg, minus_next;
    pct_t                  adxo_reg, adxo_next;
    logic                  div_ok_reg, div_ok_next;
    logic                  adxv_reg, adxv_next;

    price_t                h, l, c, hl, t2, t3, tr, up_mv, dn_mv;
    period_t               p_eff;
    logic [COUNT_BITS-1:0] two_p_in, two_p;
    sum_t                  add_sel;
    logic [PCT_BITS:0]     di_sum;
    pct_t                  di_diff;

    logic                  div_start, div_done;
    sum_t                  div_dividend, div_quo;
    logic                  rat_start, rat_done;
    sum_t                  rat_num, rat_den;
    pct_t                  rat_q;

    wadx_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (p_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    wadx_ratio u_ratio (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rat_start),
        .num   (rat_num),
        .den   (rat_den),
        .done  (rat_done),
        .ratio (rat_q)
    );

    always_comb
    begin
        h  = bar_high[PRICE_BITS-1:0];
        l  = bar_low[PRICE_BITS-1:0];
        c  = bar_close[PRICE_BITS-1:0];
        hl = (h >= l) ? h - l : '0;
        t2 = (h >= prior_close_reg) ? h - prior_close_reg : prior_close_reg - h;
        t3 = (l >= prior_close_reg) ? l - prior_close_reg : prior_close_reg - l;
        tr = hl;
        if (t2 > tr)
        begin
            tr = t2;
        end
        if (t3 > tr)
        begin
            tr = t3;
        end
        up_mv = (h > prior_high_reg) ? h - prior_high_reg : '0;
        dn_mv = (prior_low_reg > l) ? prior_low_reg - l : '0;

        if (period_reg == '0)
        begin
            p_eff = period_t'(1);
        end
        else if (period_reg > PERIOD_TOP)
        begin
            p_eff = PERIOD_TOP;
        end
        else
        begin
            p_eff = period_reg;
        end
        two_p_in = COUNT_BITS'(p_eff) << 1;
        two_p    = COUNT_BITS'(p_reg) << 1;

        case (k_reg)
            2'd0:    add_sel = {{PAD_BITS{1'b0}}, tr_reg, {FRAC_BITS{1'b0}}};
            2'd1:    add_sel = {{PAD_BITS{1'b0}}, pdm_reg, {FRAC_BITS{1'b0}}};
            default: add_sel = {{PAD_BITS{1'b0}}, mdm_reg, {FRAC_BITS{1'b0}}};
        endcase

        di_sum  = {1'b0, pdi_reg} + {1'b0, mdi_reg};
        di_diff = (pdi_reg >= mdi_reg) ? pdi_reg - mdi_reg : mdi_reg - pdi_reg;

        div_start    = 1'b0;
        div_dividend = '0;
        rat_start    = 1'b0;
        rat_num      = '0;
        rat_den      = '0;

        state_next       = state_reg;
        period_next      = cfg_we ? cfg_data : period_reg;
        prior_high_next  = prior_high_reg;
        prior_low_next   = prior_low_reg;
        prior_close_next = prior_close_reg;
        bars_next        = bars_reg;
        range_next       = range_reg;
        up_next          = up_reg;
        down_next        = down_reg;
        seed_next        = seed_reg;
        adx_next         = adx_reg;
        undef_next       = undef_reg;
        tr_next          = tr_reg;
        pdm_next         = pdm_reg;
        mdm_next         = mdm_reg;
        p_next           = p_reg;
        i_next           = i_reg;
        k_next           = k_reg;
        pdi_next         = pdi_reg;
        mdi_next         = mdi_reg;
        dx_next          = dx_reg;
        mul_next         = mul_reg;
        di_ok_next       = di_ok_reg;
        adx_ok_next      = adx_ok_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        plus_next        = plus_reg;
        minus_next       = minus_reg;
        adxo_next        = adxo_reg;
        div_ok_next      = div_ok_reg;
        adxv_next        = adxv_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    tr_next          = tr;
                    pdm_next         = (up_mv > dn_mv) ? up_mv : '0;
                    mdm_next         = (dn_mv > up_mv) ? dn_mv : '0;
                    p_next           = p_eff;
                    i_next           = bars_reg;
                    k_next           = 2'd0;
                    pdi_next         = '0;
                    mdi_next         = '0;
                    dx_next          = '0;
                    di_ok_next       = 1'b0;
                    adx_ok_next      = 1'b0;
                    prior_high_next  = h;
                    prior_low_next   = l;
                    prior_close_next = c;
                    if (bars_reg < two_p_in)
                    begin
                        bars_next = bars_reg + 1'b1;
                    end
                    state_next = (bars_reg == '0) ? ST_OUT : ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (i_reg <= COUNT_BITS'(p_reg))
                begin
                    range_next = range_reg + {{PAD_BITS{1'b0}}, tr_reg, {FRAC_BITS{1'b0}}};
                    up_next    = up_reg + {{PAD_BITS{1'b0}}, pdm_reg, {FRAC_BITS{1'b0}}};
                    down_next  = down_reg + {{PAD_BITS{1'b0}}, mdm_reg, {FRAC_BITS{1'b0}}};
                    state_next = ST_PHASE;
                end
                else
                begin
                    div_start = 1'b1;
                    case (k_reg)
                        2'd0:    div_dividend = range_reg;
                        2'd1:    div_dividend = up_reg;
                        default: div_dividend = down_reg;
                    endcase
                    state_next = ST_DIVW;
                end
            end
            ST_DIVW:
            begin
                if (div_done)
                begin
                    case (k_reg)
                        2'd0:    range_next = range_reg - div_quo + add_sel;
                        2'd1:    up_next = up_reg - div_quo + add_sel;
                        default: down_next = down_reg - div_quo + add_sel;
                    endcase
                    if (k_reg == 2'd2)
                    begin
                        state_next = ST_PHASE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_SUM;
                    end
                end
            end
            ST_PHASE:
            begin
                k_next = 2'd0;
                if (i_reg < COUNT_BITS'(p_reg))
                begin
                    state_next = ST_OUT;
                end
                else if (range_reg == '0)
                begin
                    undef_next = 1'b1;
                    dx_next    = '0;
                    state_next = ST_ADX;
                end
                else
                begin
                    state_next = ST_RSTART;
                end
            end
            ST_RSTART:
            begin
                rat_start  = 1'b1;
                rat_num    = (k_reg == 2'd0) ? up_reg : down_reg;
                rat_den    = range_reg;
                state_next = ST_RWAIT;
            end
            ST_RWAIT:
            begin
                if (rat_done)
                begin
                    case (k_reg)
                        2'd0:
                        begin
                            pdi_next   = rat_q;
                            k_next     = 2'd1;
                            state_next = ST_RSTART;
                        end
                        2'd1:
                        begin
                            mdi_next   = rat_q;
                            di_ok_next = 1'b1;
                            state_next = ST_DX;
                        end
                        default:
                        begin
                            dx_next    = rat_q;
                            state_next = ST_ADX;
                        end
                    endcase
                end
            end
            ST_DX:
            begin
                if (di_sum == '0)
                begin
                    dx_next    = '0;
                    state_next = ST_ADX;
                end
                else
                begin
                    rat_start  = 1'b1;
                    rat_num    = SUM_BITS'(di_diff);
                    rat_den    = SUM_BITS'(di_sum);
                    k_next     = 2'd2;
                    state_next = ST_RWAIT;
                end
            end
            ST_ADX:
            begin
                if (i_reg < two_p)
                begin
                    seed_next = seed_reg + SEED_BITS'(dx_reg);
                    if (i_reg == two_p - 1'b1)
                    begin
                        div_start    = 1'b1;
                        div_dividend = SUM_BITS'(seed_reg + SEED_BITS'(dx_reg));
                        state_next   = ST_AWAIT;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
                else
                begin
                    mul_next   = MUL_BITS'(adx_reg) * MUL_BITS'(p_reg - 1'b1)
                                 + MUL_BITS'(dx_reg);
                    state_next = ST_AMUL;
                end
            end
            ST_AMUL:
            begin
                div_start    = 1'b1;
                div_dividend = SUM_BITS'(mul_reg);
                state_next   = ST_AWAIT;
            end
            ST_AWAIT:
            begin
                if (div_done)
                begin
                    adx_next    = div_quo[PCT_BITS-1:0];
                    adx_ok_next = !undef_reg;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    plus_next      = di_ok_reg ? pdi_reg : '0;
                    minus_next     = di_ok_reg ? mdi_reg : '0;
                    adxo_next      = adx_ok_reg ? adx_reg : '0;
                    div_ok_next    = di_ok_reg;
                    adxv_next      = adx_ok_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            period_reg      <= PERIOD_RESET;
            prior_high_reg  <= '0;
            prior_low_reg   <= '0;
            prior_close_reg <= '0;
            bars_reg        <= '0;
            range_reg       <= '0;
            up_reg          <= '0;
            down_reg        <= '0;
            seed_reg        <= '0;
            adx_reg         <= '0;
            undef_reg       <= 1'b0;
            k_reg           <= '0;
            di_ok_reg       <= 1'b0;
            adx_ok_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            div_ok_reg      <= 1'b0;
            adxv_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            period_reg      <= period_next;
            prior_high_reg  <= prior_high_next;
            prior_low_reg   <= prior_low_next;
            prior_close_reg <= prior_close_next;
            bars_reg        <= bars_next;
            range_reg       <= range_next;
            up_reg          <= up_next;
            down_reg        <= down_next;
            seed_reg        <= seed_next;
            adx_reg         <= adx_next;
            undef_reg       <= undef_next;
            k_reg           <= k_next;
            di_ok_reg       <= di_ok_next;
            adx_ok_reg      <= adx_ok_next;
            out_valid_reg   <= out_valid_next;
            div_ok_reg      <= div_ok_next;
            adxv_reg        <= adxv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tr_reg    <= tr_next;
        pdm_reg   <= pdm_next;
        mdm_reg   <= mdm_next;
        p_reg     <= p_next;
        i_reg     <= i_next;
        pdi_reg   <= pdi_next;
        mdi_reg   <= mdi_next;
        dx_reg    <= dx_next;
        mul_reg   <= mul_next;
        plus_reg  <= plus_next;
        minus_reg <= minus_next;
        adxo_reg  <= adxo_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign plus_di   = plus_reg;
    assign down_di   = minus_reg;
    assign adx_value = adxo_reg;
    assign di_valid  = div_ok_reg;
    assign adx_valid = adxv_reg;

    // A defined ADX needs defined DI values on the same item.
    a_adx_needs_di: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && adx_valid |-> di_valid)
        else $error("ADX flagged valid without valid DI");

    // Once a DX was undefined, no later ADX may be flagged valid.
    a_adx_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        undef_reg |-> !adx_ok_reg)
        else $error("ADX flagged valid after an undefined DX");

    // The bar count never passes twice the largest period.
    a_bars_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bars_reg <= COUNT_BITS'(2 * PERIOD_MAX))
        else $error("Bar count beyond its saturation point");

    // Directional indicators never exceed one hundred percent.
    a_di_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (plus_di <= PCT_SCALE) && (down_di <= PCT_SCALE))
        else $error("DI above full scale");

endmodule
